>>> design/assert_macros.svh
// assertion macros used by the checker file of the correlation engine
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

`endif

>>> design/ccorr_pkg.sv
// types and constants of the circular correlation engine
// no dependencies; imported by the top level and the checker
package ccorr_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 16;
  localparam int CFG_W  = 4;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 48;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_WRITE_KERNEL = 2'd0;
  localparam op_t OP_WRITE_GRID   = 2'd1;
  localparam op_t OP_COMPUTE      = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

  // stream layout, lowest bit first
  localparam int TDATA_W   = 32;
  localparam int IDX_LSB   = 0;
  localparam int VAL_LSB   = IDX_LSB + IDX_W;
  localparam int TDATA_USED = VAL_LSB + VAL_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

endpackage

>>> design/ccorr_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module ccorr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/circular_correlation_engine.sv
// a compute transaction sums N products of the kernel and grid rams, N = 2^n with
// n the clamped cells_log2_in_use; one multiply-accumulate per cycle against one
// read port of each ram. the next item is taken the cycle after the result
// is loaded; write transactions give no result and leave the block idle.
// reset clears control state and sets cells_log2_in_use to 12; the kernel and grid
// rams are not cleared.
module circular_correlation_engine import ccorr_pkg::*; #(
  parameter int CELLS_LOG2 = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // cell_index, value, zero pad
  input  logic [OP_W-1:0]    s_tuser,   // operation
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // result_index, result_value, zero pad
  output logic               m_tuser,   // saturated
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int AW = CELLS_LOG2;
  localparam int DEPTH = 1 << CELLS_LOG2;
  localparam logic [4:0] N_MAX = 5'(CELLS_LOG2);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [CFG_W-1:0]  cells_log2;
  logic [4:0]        n_eff;
  logic [IDX_W-1:0]  idx_mask;
  logic [AW-1:0]     addr_mask;

  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  idx_masked;
  logic [AW+IDX_W-1:0] idx_wide;
  logic [AW-1:0]     in_addr;
  op_t               in_op;
  logic              in_acc;

  logic [AW-1:0]     cnt;
  logic [AW-1:0]     idx_addr;
  logic [IDX_W-1:0]  res_idx;
  logic [AW-1:0]     k_raddr;
  logic [VAL_W-1:0]  k_rdata;
  logic [VAL_W-1:0]  g_rdata;
  logic              rd_vld;
  logic              prod_vld;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic              sat;
  logic              load;

  logic              out_valid;
  logic [IDX_W-1:0]  out_idx;
  logic [VAL_W-1:0]  out_val;
  logic              out_sat;

  // register value 0 acts as 1, values above the store size are clamped
  always_comb begin
    if (cells_log2 == '0) begin
      n_eff = 5'd1;
    end else if ({1'b0, cells_log2} > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = {1'b0, cells_log2};
    end
    for (int b = 0; b < IDX_W; b++) begin
      idx_mask[b] = (5'(b) < n_eff);
    end
    for (int b = 0; b < AW; b++) begin
      addr_mask[b] = (5'(b) < n_eff);
    end
  end

  assign in_op      = s_tuser;
  assign in_idx     = s_tdata[IDX_LSB +: IDX_W];
  assign idx_masked = in_idx & idx_mask;
  assign idx_wide   = {{AW{1'b0}}, idx_masked};
  assign in_addr    = idx_wide[AW-1:0];
  assign s_tready   = (state == ST_IDLE);
  assign in_acc     = s_tvalid && s_tready;

  assign k_raddr = (cnt - idx_addr) & addr_mask;
  assign sat     = |acc[ACC_W-1:PROD_W];
  assign load    = (state == ST_DRAIN) && !rd_vld && !prod_vld && (!out_valid || m_tready);

  ccorr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_kernel_ram (
    .clk   (clk),
    .we    (in_acc && (in_op == OP_WRITE_KERNEL)),
    .waddr (in_addr),
    .wdata (s_tdata[VAL_LSB +: VAL_W]),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  ccorr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (in_acc && (in_op == OP_WRITE_GRID)),
    .waddr (in_addr),
    .wdata (s_tdata[VAL_LSB +: VAL_W]),
    .raddr (cnt),
    .rdata (g_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cells_log2 <= CFG_RESET;
      rd_vld     <= 1'b0;
      prod_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cells_log2 <= cfg_wdata;
      end
      rd_vld   <= (state == ST_RUN);
      prod_vld <= rd_vld;
      // a new result may replace the one taken in the same cycle
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_op == OP_COMPUTE)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt == addr_mask) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: ram read, registered product, accumulate
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_COMPUTE)) begin
      cnt      <= '0;
      acc      <= '0;
      idx_addr <= in_addr;
      res_idx  <= idx_masked;
    end else begin
      if (state == ST_RUN) begin
        cnt <= cnt + 1'b1;
      end
      if (prod_vld) begin
        acc <= acc + {{(ACC_W-PROD_W){1'b0}}, prod};
      end
    end
    if (rd_vld) begin
      prod <= g_rdata * k_rdata;
    end
    if (load) begin
      out_idx <= res_idx;
      out_val <= sat ? VAL_MAX : acc[PROD_W-1:VAL_W];
      out_sat <= sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_W-TDATA_USED){1'b0}}, out_val, out_idx};
  assign m_tuser  = out_sat;

endmodule

>>> design/ccorr_checker.sv
// port-level checks of the circular correlation engine, bound to the top level
// depends on ccorr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccorr_checker import ccorr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [OP_W-1:0]    s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser
);

  logic s_acc;
  logic stall;

  assign s_acc = s_tvalid && s_tready;
  assign stall = m_tvalid && !m_tready;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // a compute transaction keeps the block busy for at least the next cycle
  `ASSERT_NEXT(a_compute_busy, clk, rst, s_acc && (s_tuser == OP_COMPUTE), !s_tready)
  // no transaction makes a result appear in the next cycle
  `ASSERT_NEXT(a_no_early_result, clk, rst, s_acc && !m_tvalid, !m_tvalid)
  // a clamped sum reads as full scale
  `ASSERT_SAME(a_sat_value, clk, rst, m_tvalid && m_tuser,
               (m_tdata[VAL_LSB +: VAL_W] == VAL_MAX))
  // unused bits of the result stay zero
  `ASSERT_SAME(a_pad_zero, clk, rst, m_tvalid, (m_tdata[TDATA_W-1:TDATA_USED] == '0))

endmodule

bind circular_correlation_engine ccorr_checker u_ccorr_checker (.*);

>>> tb/circular_correlation_engine_tb.sv
// testbench for circular_correlation_engine: a local predictor models the kernel and grid
// stores and the circular correlation sum; stream results are checked field by field
// depends on ccorr_pkg and the circular_correlation_engine rtl
module circular_correlation_engine_tb;
  import ccorr_pkg::*;

  localparam int CELLS_LOG2 = 12;
  localparam int DEPTH = 1 << CELLS_LOG2;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int FILL_CELLS = 8;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] total;
    logic             sat;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata;   // cell_index, value, zero pad
  logic [OP_W-1:0] s_tuser;      // operation
  logic m_tvalid;
  logic m_tready;
  logic [TDATA_W-1:0] m_tdata;   // result_index, result_value, zero pad
  logic m_tuser;                 // saturated
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic [VAL_W-1:0] kernel_weights [DEPTH];
  logic [VAL_W-1:0] grid_cells [DEPTH];
  logic [CFG_W-1:0] size_log2 = CFG_RESET;
  corr_result_t pending_sums[$];

  int failures = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_len = 0;

  circular_correlation_engine #(.CELLS_LOG2(CELLS_LOG2)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int cells_now();
    int n;
    n = int'(size_log2);
    if (n < 1) n = 1;
    if (n > CELLS_LOG2) n = CELLS_LOG2;
    return 1 << n;
  endfunction

  function automatic corr_result_t correlate(logic [IDX_W-1:0] raw_index);
    int n;
    int i;
    int k;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] shifted;
    corr_result_t r;
    n = cells_now();
    i = int'(raw_index) & (n - 1);
    acc = '0;
    for (int j = 0; j < n; j++) begin
      k = (j - i) & (n - 1);
      acc = acc + ACC_W'(grid_cells[j]) * ACC_W'(kernel_weights[k]);
    end
    shifted = acc >> 16;
    r.index = IDX_W'(i);
    r.sat = (shifted > ACC_W'(VAL_MAX));
    r.total = r.sat ? VAL_MAX : shifted[VAL_W-1:0];
    return r;
  endfunction

  // predictor: follows every accepted transaction and register write
  always @(posedge clk) begin
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    int masked;
    if (!rst) begin
      if (cfg_we) size_log2 = cfg_wdata;
      if (s_tvalid && s_tready) begin
        idx = s_tdata[IDX_LSB +: IDX_W];
        val = s_tdata[VAL_LSB +: VAL_W];
        masked = int'(idx) & (cells_now() - 1);
        case (op_t'(s_tuser))
          OP_WRITE_KERNEL: kernel_weights[masked] = val;
          OP_WRITE_GRID:   grid_cells[masked] = val;
          OP_COMPUTE:      pending_sums.push_back(correlate(idx));
          default: ;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    corr_result_t want;
    corr_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.index = m_tdata[IDX_LSB +: IDX_W];
      got.total = m_tdata[VAL_LSB +: VAL_W];
      got.sat = m_tuser;
      if (pending_sums.size() == 0) begin
        failures++;
        $display("%0t: unexpected result index=%0d value=%0d sat=%0b", $time,
                 got.index, got.total, got.sat);
      end else begin
        want = pending_sums.pop_front();
        if (got.index !== want.index) begin
          failures++;
          $display("%0t: result_index mismatch expected %0d actual %0d", $time,
                   want.index, got.index);
        end
        if (got.total !== want.total) begin
          failures++;
          $display("%0t: result_value mismatch expected %0d actual %0d", $time,
                   want.total, got.total);
        end
        if (got.sat !== want.sat) begin
          failures++;
          $display("%0t: saturated mismatch expected %0b actual %0b", $time,
                   want.sat, got.sat);
        end
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // one transaction; entered and left right after a rising edge
  task automatic send_op(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    if (!steady && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(TDATA_W - TDATA_USED){1'b0}}, val, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    // trailing writes give no result, so allow the block to settle
    repeat (16) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_filled_stores();
    // the first eight entries of both stores get written here, so later computes
    // at sizes up to eight cells never read unwritten cells
    write_size(4'd3);
    for (int i = 0; i < FILL_CELLS; i++) begin
      send_op(OP_WRITE_KERNEL, IDX_W'(i), VAL_W'($urandom_range(0, 65535)));
      send_op(OP_WRITE_GRID, IDX_W'(i), VAL_W'($urandom_range(0, 65535)));
    end
    send_op(OP_COMPUTE, '0, '0);
    send_op(OP_COMPUTE, {IDX_W{1'b1}}, VAL_MAX);
    drain();
  endtask

  task automatic test_smallest_size();
    write_size(4'd0);  // zero acts as one, two cells
    send_op(OP_WRITE_KERNEL, 12'd0, '0);
    send_op(OP_WRITE_KERNEL, 12'hFFF, VAL_MAX);  // masked to 1
    send_op(OP_WRITE_GRID, 12'd0, VAL_MAX);
    send_op(OP_WRITE_GRID, 12'hFFE, 16'h8001);   // masked to 0
    send_op(OP_WRITE_GRID, 12'd1, 16'h0003);
    send_op(OP_COMPUTE, 12'd0, '0);
    send_op(OP_COMPUTE, 12'hFFF, VAL_MAX);
    // unknown operation must leave the stores alone
    send_op(OP_UNUSED, 12'd0, 16'h1234);
    send_op(OP_UNUSED, 12'hFFF, VAL_MAX);
    send_op(OP_COMPUTE, 12'd2, '0);
    drain();
    write_size(4'd1);
    send_op(OP_WRITE_GRID, 12'd0, '0);
    send_op(OP_WRITE_GRID, 12'd1, '0);
    send_op(OP_COMPUTE, 12'd1, '0);
    send_op(OP_WRITE_GRID, 12'd0, VAL_MAX);
    send_op(OP_WRITE_GRID, 12'd1, VAL_MAX);
    send_op(OP_WRITE_KERNEL, 12'd0, VAL_MAX);
    send_op(OP_COMPUTE, 12'd0, '0);
    send_op(OP_COMPUTE, 12'd1, '0);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] sizes [4];
    int pick;
    logic [VAL_W-1:0] val;
    sizes = '{4'd3, 4'd1, 4'd2, 4'd3};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      steady = (p == 1);
      for (int n = 0; n < 20; n++) begin
        pick = $urandom_range(0, 99);
        val = VAL_W'($urandom_range(0, 65535));
        // small values keep larger sums below the clamp now and then
        if ($urandom_range(0, 1)) val = val >> $urandom_range(0, 12);
        if (pick < 30) send_op(OP_WRITE_KERNEL, IDX_W'($urandom_range(0, DEPTH - 1)), val);
        else if (pick < 60) send_op(OP_WRITE_GRID, IDX_W'($urandom_range(0, DEPTH - 1)), val);
        else if (pick < 92) send_op(OP_COMPUTE, IDX_W'($urandom_range(0, DEPTH - 1)), val);
        else send_op(OP_UNUSED, IDX_W'($urandom_range(0, DEPTH - 1)), val);
      end
      drain();
    end
    steady = 1'b0;
  endtask

  task automatic test_output_stall();
    write_size(4'd3);
    hold_len = 400;
    hold_req = 1'b1;
    // the block fills up behind the held result and stalls its input
    for (int n = 0; n < 10; n++) begin
      send_op(OP_WRITE_GRID, IDX_W'($urandom_range(0, DEPTH - 1)),
              VAL_W'($urandom_range(0, 4095)));
      send_op(OP_COMPUTE, IDX_W'($urandom_range(0, DEPTH - 1)), '0);
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_WRITE_KERNEL;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_smallest_size();
    test_filled_stores();
    test_random_traffic();
    test_output_stall();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule

>>> circular_correlation_engine.f
+incdir+design
design/ccorr_pkg.sv
design/ccorr_ram.sv
design/circular_correlation_engine.sv
design/ccorr_checker.sv
tb/circular_correlation_engine_tb.sv
